// ----- design/wbfr_pkg.sv -----
package wbfr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int PLEN_W      = 4;
    localparam int IDX_W       = 3;
    localparam int CFG_W       = 64;
    localparam int CNT_W       = 16;
    localparam int MAX_W       = 17;

    localparam logic [IDX_W-1:0] CFG_PATTERN = 3'd0;
    localparam logic [IDX_W-1:0] CFG_WILD    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_PLEN    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_REPLACE = 3'd3;
    localparam logic [IDX_W-1:0] CFG_KEEP    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_RLEN    = 3'd5;
    localparam logic [IDX_W-1:0] CFG_MIN     = 3'd6;
    localparam logic [IDX_W-1:0] CFG_MAX     = 3'd7;

    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic wr;
        logic shift;
    } t_win_ctl;

    typedef struct packed {
        logic load;
        logic shift;
    } t_out_ctl;

endpackage

// ----- design/wbfr_in_if.sv -----
interface wbfr_in_if;
    logic valid;
    logic ready;
    logic [7:0] data_byte;
    logic stream_last;

    modport source (output valid, output data_byte, output stream_last, input ready);
    modport sink (input valid, input data_byte, input stream_last, output ready);
endinterface

// ----- design/wbfr_out_if.sv -----
interface wbfr_out_if;
    logic valid;
    logic ready;
    logic [7:0] out_byte;
    logic run_last;
    logic stream_done;
    logic [15:0] match_total;

    modport source (output valid, output out_byte, output run_last, output stream_done,
                    output match_total, input ready);
    modport sink (input valid, input out_byte, input run_last, input stream_done,
                  input match_total, output ready);
endinterface

// ----- design/wbfr_win_cell.sv -----
module wbfr_win_cell (
    input  logic               i_clk,
    input  wbfr_pkg::t_win_ctl i_ctl,
    input  wbfr_pkg::t_byte    i_byte,
    input  wbfr_pkg::t_byte    i_nb_byte,
    input  wbfr_pkg::t_byte    i_pat,
    input  logic               i_wild,
    input  logic               i_active,
    output wbfr_pkg::t_byte    o_cur,
    output logic               o_hit
);
    import wbfr_pkg::*;

    t_byte r_byte;
    t_byte n_byte;
    t_byte w_cur;

    assign w_cur = i_ctl.wr ? i_byte : r_byte;
    assign o_cur = w_cur;
    assign o_hit = !i_active || i_wild || (w_cur == i_pat);
    assign n_byte = i_ctl.shift ? i_nb_byte : w_cur;

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end
endmodule

// ----- design/wbfr_out_cell.sv -----
module wbfr_out_cell (
    input  logic               i_clk,
    input  wbfr_pkg::t_out_ctl i_ctl,
    input  wbfr_pkg::t_byte    i_load,
    input  wbfr_pkg::t_byte    i_nb_byte,
    output wbfr_pkg::t_byte    o_byte
);
    import wbfr_pkg::*;

    t_byte r_byte;
    t_byte n_byte;

    always_comb begin
        if (i_ctl.load) begin
            n_byte = i_load;
        end else if (i_ctl.shift) begin
            n_byte = i_nb_byte;
        end else begin
            n_byte = r_byte;
        end
    end

    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end
endmodule

// ----- design/wildcard_byte_find_replace.sv -----
// channel   dir  signals                                          accepted when
// i_req     in   data_byte, stream_last                           valid && ready
// o_rsp     out  out_byte, run_last, stream_done, match_total     valid && ready
// i_cfg_*   in   we, idx, data                                    we high
//
// all of a request's results are loaded at once, when it is taken, into a shift chain
// of eight output cells that hands out one result per cycle while the output is ready.
// a request holds the output until all of its results have left; the next request is taken
// in the cycle the last of them leaves, so one request per cycle when each gives one and no stall.
// reset (synchronous) clears counters and fill and sets configuration to its defaults; window bytes need none.
// an output stall holds the chain and the input stays not ready.
module wildcard_byte_find_replace (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wbfr_in_if.sink                       i_req,
    wbfr_out_if.source                    o_rsp,
    input  logic                          i_cfg_we,
    input  logic [wbfr_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [wbfr_pkg::CFG_W-1:0]    i_cfg_data
);
    import wbfr_pkg::*;

    localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(MAX_PATTERN);

    logic [63:0]        r_pat;
    logic [7:0]         r_wild;
    logic [PLEN_W-1:0]  r_plen;
    logic [63:0]        r_repl;
    logic [7:0]         r_keep;
    logic [PLEN_W-1:0]  r_rlen;
    logic [CNT_W-1:0]   r_min;
    logic [MAX_W-1:0]   r_max;

    logic [PLEN_W-1:0]  r_fill;
    logic [PLEN_W-1:0]  n_fill;
    logic [CNT_W-1:0]   r_mcnt;
    logic [CNT_W-1:0]   n_mcnt;
    logic [PLEN_W-1:0]  r_ocnt;
    logic [PLEN_W-1:0]  n_ocnt;
    logic [CNT_W-1:0]   r_otot;
    logic               r_olast;

    logic [PLEN_W-1:0]  plen;
    logic [PLEN_W-1:0]  rlen;
    logic [PLEN_W-1:0]  f0;
    logic [PLEN_W-1:0]  f1;
    logic               full;
    logic               enabled;
    logic               hit;
    logic               match;
    logic               pass;
    logic               sel_rep;
    logic [MAX_W-1:0]   number;
    logic [CNT_W-1:0]   mcnt_upd;
    logic               accept;
    logic               pop;
    logic               in_ready;

    t_byte              w_cur [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_hit;
    t_byte              o_cell [MAX_PATTERN];
    t_byte              o_load [MAX_PATTERN];
    t_out_ctl           out_ctl;

    always_comb begin
        if (r_plen == '0) begin
            plen = PLEN_W'(1);
        end else if (r_plen > PLEN_MAX) begin
            plen = PLEN_MAX;
        end else begin
            plen = r_plen;
        end
        rlen = (r_rlen > PLEN_W'(8)) ? PLEN_W'(8) : r_rlen;
    end

    assign pop      = o_rsp.valid && o_rsp.ready;
    assign in_ready = (r_ocnt == '0) || ((r_ocnt == PLEN_W'(1)) && o_rsp.ready);
    assign i_req.ready = in_ready;
    assign accept   = i_req.valid && in_ready;

    assign f0      = (r_fill >= plen) ? '0 : r_fill;
    assign f1      = f0 + PLEN_W'(1);
    assign full    = (f1 == plen);
    assign enabled = r_max[MAX_W-1] || (r_mcnt < r_max[CNT_W-1:0]);
    assign hit     = &w_hit;
    assign match   = full && enabled && hit;
    assign number  = {1'b0, r_mcnt} + MAX_W'(1);
    assign pass    = (rlen == '0) || (number < {1'b0, r_min});
    assign sel_rep = match && !pass;
    assign mcnt_upd = (match && (r_mcnt != CNT_SAT)) ? r_mcnt + CNT_W'(1) : r_mcnt;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_win
            t_win_ctl win_ctl;
            t_byte    nb;
            assign win_ctl.wr    = accept && (f0 == PLEN_W'(gi));
            assign win_ctl.shift = accept && full && !match;
            if (gi == MAX_PATTERN - 1) begin : g_end
                assign nb = '0;
            end else begin : g_mid
                assign nb = w_cur[gi+1];
            end
            wbfr_win_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (win_ctl),
                .i_byte    (i_req.data_byte),
                .i_nb_byte (nb),
                .i_pat     (r_pat[8*gi +: 8]),
                .i_wild    (r_wild[gi]),
                .i_active  (PLEN_W'(gi) < plen),
                .o_cur     (w_cur[gi]),
                .o_hit     (w_hit[gi])
            );
        end
    endgenerate

    assign out_ctl.load  = accept;
    assign out_ctl.shift = pop;

    generate
        for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_out
            t_byte rep;
            t_byte onb;
            assign rep = (r_keep[gi] && (PLEN_W'(gi) < plen)) ? w_cur[gi] : r_repl[8*gi +: 8];
            assign o_load[gi] = sel_rep ? rep : w_cur[gi];
            if (gi == MAX_PATTERN - 1) begin : g_end
                assign onb = '0;
            end else begin : g_mid
                assign onb = o_cell[gi+1];
            end
            wbfr_out_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (out_ctl),
                .i_load    (o_load[gi]),
                .i_nb_byte (onb),
                .o_byte    (o_cell[gi])
            );
        end
    endgenerate

    always_comb begin
        if (full && match) begin
            n_ocnt = pass ? plen : rlen;
        end else if (full) begin
            n_ocnt = i_req.stream_last ? plen : PLEN_W'(1);
        end else begin
            n_ocnt = i_req.stream_last ? f1 : '0;
        end

        if (i_req.stream_last || match) begin
            n_fill = '0;
        end else if (full) begin
            n_fill = plen - PLEN_W'(1);
        end else begin
            n_fill = f1;
        end

        n_mcnt = i_req.stream_last ? '0 : mcnt_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_wild <= '0;
            r_plen <= PLEN_W'(1);
            r_repl <= '0;
            r_keep <= '0;
            r_rlen <= '0;
            r_min  <= '0;
            r_max  <= '1;
            r_fill <= '0;
            r_mcnt <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PATTERN: r_pat  <= i_cfg_data;
                    CFG_WILD:    r_wild <= i_cfg_data[7:0];
                    CFG_PLEN:    r_plen <= i_cfg_data[PLEN_W-1:0];
                    CFG_REPLACE: r_repl <= i_cfg_data;
                    CFG_KEEP:    r_keep <= i_cfg_data[7:0];
                    CFG_RLEN:    r_rlen <= i_cfg_data[PLEN_W-1:0];
                    CFG_MIN:     r_min  <= i_cfg_data[CNT_W-1:0];
                    CFG_MAX:     r_max  <= i_cfg_data[MAX_W-1:0];
                endcase
            end
            if (i_cfg_we && (i_cfg_idx == CFG_PLEN)) begin
                r_fill <= '0;
            end else if (accept) begin
                r_fill <= n_fill;
            end
            if (accept) begin
                r_mcnt <= n_mcnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= '0;
        end else if (accept) begin
            r_ocnt <= n_ocnt;
        end else if (pop) begin
            r_ocnt <= r_ocnt - PLEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_otot  <= mcnt_upd;
            r_olast <= i_req.stream_last;
        end
    end

    assign o_rsp.valid       = (r_ocnt != '0);
    assign o_rsp.out_byte    = o_cell[0];
    assign o_rsp.run_last    = (r_ocnt == PLEN_W'(1));
    assign o_rsp.stream_done = r_olast && (r_ocnt == PLEN_W'(1));
    assign o_rsp.match_total = r_otot;
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import wbfr_pkg::*;

    typedef struct {
        logic [7:0] data_byte;
        logic       stream_last;
    } t_stream_byte;

    typedef struct {
        logic [7:0]       out_byte;
        logic             run_last;
        logic             stream_done;
        logic [CNT_W-1:0] match_total;
    } t_edited_byte;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    wbfr_in_if  req_if ();
    wbfr_out_if rsp_if ();

    wildcard_byte_find_replace dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the window, counters and registers
    logic [7:0]  win [MAX_PATTERN];
    int          win_fill;
    int          hits;
    logic [63:0] pat_r;
    logic [7:0]  wild_r;
    logic [3:0]  plen_r;
    logic [63:0] rep_r;
    logic [7:0]  keep_r;
    logic [3:0]  rlen_r;
    logic [15:0] min_r;
    int          max_lim;

    t_stream_byte stream_q [$];
    t_edited_byte edited_q [$];

    int   push_cnt = 0;
    int   acc_cnt = 0;
    int   beats = 0;
    int   res_cnt = 0;
    int   stream_cnt = 0;
    int   match_cnt = 0;
    int   cfg_cnt = 0;
    int   fail_cnt = 0;
    int   snd_pct = 0;
    int   rcv_pct = 0;
    logic req_acc = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int eff_plen();
        if (plen_r == 0) return 1;
        if (plen_r > MAX_PATTERN) return MAX_PATTERN;
        return plen_r;
    endfunction

    function automatic void edit_step(input logic [7:0] b, input logic last);
        logic [7:0]   outs [$];
        t_edited_byte e;
        int           plen;
        int           rlen;
        int           num;
        int           i;
        bit           hit;
        plen = eff_plen();
        rlen = (rlen_r > 8) ? 8 : rlen_r;
        if (win_fill >= plen) win_fill = 0;
        win[win_fill] = b;
        win_fill++;
        if (win_fill == plen) begin
            hit = (max_lim < 0) || (hits < max_lim);
            for (i = 0; i < plen; i++)
                if (!wild_r[i] && win[i] !== pat_r[8*i +: 8]) hit = 1'b0;
            if (hit) begin
                num = hits + 1;
                match_cnt++;
                if (hits < CNT_SAT) hits++;
                if (rlen == 0 || num < min_r) begin
                    for (i = 0; i < plen; i++) outs.push_back(win[i]);
                end else begin
                    for (i = 0; i < rlen; i++)
                        outs.push_back((keep_r[i] && i < plen) ? win[i] : rep_r[8*i +: 8]);
                end
                win_fill = 0;
            end else begin
                outs.push_back(win[0]);
                for (i = 1; i < plen; i++) win[i-1] = win[i];
                win_fill = plen - 1;
            end
        end
        if (last) begin
            for (i = 0; i < win_fill; i++) outs.push_back(win[i]);
            win_fill = 0;
        end
        for (i = 0; i < outs.size(); i++) begin
            e.out_byte    = outs[i];
            e.run_last    = (i == outs.size() - 1);
            e.stream_done = e.run_last && last;
            e.match_total = hits[15:0];
            edited_q.push_back(e);
        end
        if (last) hits = 0;
    endfunction

    always @(negedge i_clk) begin : drive
        t_stream_byte nxt;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_acc) begin
            if (stream_q.size() != 0 && $urandom_range(0, 99) >= snd_pct) begin
                nxt = stream_q.pop_front();
                req_if.valid       <= 1'b1;
                req_if.data_byte   <= nxt.data_byte;
                req_if.stream_last <= nxt.stream_last;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
        rsp_if.ready <= ($urandom_range(0, 99) >= rcv_pct);
    end

    always @(posedge i_clk) begin : watch
        t_edited_byte want;
        req_acc <= req_if.valid && req_if.ready;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                beats++;
                res_cnt++;
                if (edited_q.size() == 0) begin
                    $error("unexpected result, out_byte %h", rsp_if.out_byte);
                    fail_cnt++;
                end else begin
                    want = edited_q.pop_front();
                    if (rsp_if.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h", want.out_byte, rsp_if.out_byte);
                        fail_cnt++;
                    end
                    if (rsp_if.run_last !== want.run_last) begin
                        $error("run_last: expected %b, got %b", want.run_last, rsp_if.run_last);
                        fail_cnt++;
                    end
                    if (rsp_if.stream_done !== want.stream_done) begin
                        $error("stream_done: expected %b, got %b",
                               want.stream_done, rsp_if.stream_done);
                        fail_cnt++;
                    end
                    if (rsp_if.match_total !== want.match_total) begin
                        $error("match_total: expected %0d, got %0d",
                               want.match_total, rsp_if.match_total);
                        fail_cnt++;
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                beats++;
                acc_cnt++;
                if (req_if.stream_last) stream_cnt++;
                edit_step(req_if.data_byte, req_if.stream_last);
            end
        end
    end

    task automatic send(input logic [7:0] b, input logic last);
        t_stream_byte s;
        s.data_byte   = b;
        s.stream_last = last;
        stream_q.push_back(s);
        push_cnt++;
    endtask

    task automatic drain();
        int quiet;
        int seen;
        quiet = 0;
        seen  = beats;
        while ((acc_cnt != push_cnt || edited_q.size() != 0) && quiet < 5000) begin
            @(negedge i_clk);
            if (beats != seen) begin
                seen  = beats;
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_PATTERN: pat_r = val;
            CFG_WILD:    wild_r = val[7:0];
            CFG_PLEN: begin
                plen_r   = val[3:0];
                win_fill = 0;
            end
            CFG_REPLACE: rep_r = val;
            CFG_KEEP:    keep_r = val[7:0];
            CFG_RLEN:    rlen_r = val[3:0];
            CFG_MIN:     min_r = val[15:0];
            CFG_MAX:     max_lim = int'($signed(val[16:0]));
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_cfg(input logic [63:0] pat, input logic [7:0] wild,
                             input logic [3:0] plen, input logic [63:0] rep,
                             input logic [7:0] keep, input logic [3:0] rlen,
                             input logic [15:0] mn, input int mx);
        write_reg(CFG_PATTERN, pat);
        write_reg(CFG_WILD, wild);
        write_reg(CFG_PLEN, plen);
        write_reg(CFG_REPLACE, rep);
        write_reg(CFG_KEEP, keep);
        write_reg(CFG_RLEN, rlen);
        write_reg(CFG_MIN, mn);
        write_reg(CFG_MAX, {47'b0, 17'(mx)});
        cfg_cnt++;
    endtask

    task automatic random_cfg();
        logic [3:0]  pl;
        logic [3:0]  rl;
        logic [15:0] mn;
        logic [7:0]  wild;
        int          mx;
        case ($urandom_range(0, 5))
            0:       pl = 4'd0;
            1:       pl = 4'd1;
            2:       pl = 4'd8;
            3:       pl = 4'($urandom_range(9, 15));
            default: pl = 4'($urandom_range(2, 7));
        endcase
        case ($urandom_range(0, 4))
            0:       rl = 4'd0;
            1:       rl = 4'($urandom_range(9, 15));
            default: rl = 4'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 3))
            0:       mn = 16'd0;
            1:       mn = 16'hFFFF;
            default: mn = 16'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 5))
            0:       mx = -1;
            1:       mx = 0;
            2:       mx = 65535;
            3:       mx = -int'($urandom_range(2, 65536));
            default: mx = $urandom_range(1, 6);
        endcase
        wild = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom & $urandom);
        apply_cfg({$urandom, $urandom}, wild, pl, {$urandom, $urandom}, 8'($urandom),
                  rl, mn, mx);
    endtask

    function automatic logic [7:0] pattern_byte(input int k);
        return wild_r[k] ? 8'($urandom_range(0, 255)) : pat_r[8*k +: 8];
    endfunction

    // mostly whole or cut-off pattern copies with wildcard positions filled at random
    task automatic gen_stream(inout int cnt);
        logic [7:0] piece [$];
        int         len;
        int         pl;
        int         cut;
        int         k;
        int         r;
        pl  = eff_plen();
        len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
        while (piece.size() < len) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                for (k = 0; k < pl; k++) piece.push_back(pattern_byte(k));
            end else if (r < 75) begin
                cut = $urandom_range(0, pl - 1);
                for (k = 0; k < cut; k++) piece.push_back(pattern_byte(k));
                piece.push_back(8'($urandom_range(0, 255)));
            end else begin
                piece.push_back(8'($urandom_range(0, 255)));
            end
        end
        for (k = 0; k < piece.size(); k++) send(piece[k], k == piece.size() - 1);
        cnt += piece.size();
    endtask

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int ph;
        int n;
        int i;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        req_if.valid       = 1'b0;
        req_if.data_byte   = 8'h00;
        req_if.stream_last = 1'b0;
        rsp_if.ready       = 1'b1;
        win_fill = 0;
        hits     = 0;
        pat_r    = '0;
        wild_r   = '0;
        plen_r   = 4'd1;
        rep_r    = '0;
        keep_r   = '0;
        rlen_r   = '0;
        min_r    = '0;
        max_lim  = -1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one-byte pattern of zero, search only
        @(posedge i_clk);
        send(8'h00, 1'b0);
        send(8'hFF, 1'b1);
        drain();

        // wildcard first byte, literal 0x3f, keep bits inside and past the pattern
        apply_cfg(64'h0000_0000_443F_4200, 8'h81, 4'd4, 64'h8877_6655_4433_2211,
                  8'h42, 4'd6, 16'd0, -1);
        @(posedge i_clk);
        send(8'hFF, 1'b0);
        send(8'h42, 1'b0);
        send(8'h3F, 1'b0);
        send(8'h44, 1'b0);
        send(8'h00, 1'b0);
        send(8'h42, 1'b0);
        send(8'h3E, 1'b0);
        send(8'h44, 1'b0);
        send(8'h11, 1'b1);
        drain();

        // zero length pattern, oversized replace, min and max match limits
        apply_cfg(64'hA5, 8'h00, 4'd0, 64'h0123_4567_89AB_CDEF, 8'hFF, 4'd15, 16'd2, 3);
        @(posedge i_clk);
        for (i = 0; i < 4; i++) send(8'hA5, 1'b0);
        send(8'h00, 1'b1);
        drain();

        // oversized all-wildcard pattern, then a length change mid-stream
        apply_cfg({$urandom, $urandom}, 8'hFF, 4'd15, {$urandom, $urandom}, 8'h00,
                  4'd0, 16'hFFFF, 65535);
        @(posedge i_clk);
        send(8'h00, 1'b0);
        send(8'hFF, 1'b0);
        send(8'h55, 1'b0);
        send(8'hAA, 1'b0);
        for (i = 0; i < 7; i++) send(8'($urandom_range(0, 255)), 1'b0);
        drain();
        write_reg(CFG_PLEN, 4'd2);
        @(posedge i_clk);
        send(8'($urandom_range(0, 255)), 1'b0);
        send(8'($urandom_range(0, 255)), 1'b1);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin
                    snd_pct = 0;
                    rcv_pct = 0;
                end
                1: begin
                    snd_pct = 58;
                    rcv_pct = 0;
                end
                2: begin
                    snd_pct = 0;
                    rcv_pct = 58;
                end
                default: begin
                    snd_pct = 30;
                    rcv_pct = 30;
                end
            endcase
            random_cfg();
            @(posedge i_clk);
            n = 0;
            while (n < 32) gen_stream(n);
            drain();
        end

        if (edited_q.size() != 0 || acc_cnt != push_cnt) begin
            $error("%0d results still expected, %0d requests not taken",
                   edited_q.size(), push_cnt - acc_cnt);
            fail_cnt++;
        end
        $display("checked %0d output bytes from %0d requests in %0d streams",
                 res_cnt, acc_cnt, stream_cnt);
        $display("%0d matches over %0d register settings, with idle and stall phases",
                 match_cnt, cfg_cnt);
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/wbfr_pkg.sv
design/wbfr_in_if.sv
design/wbfr_out_if.sv
design/wbfr_win_cell.sv
design/wbfr_out_cell.sv
design/wildcard_byte_find_replace.sv
tb/tb_top.sv
